// File: rtl/mesh_flood_dedupe_filter_top_assert.svh
// Assertion macros for the flood filter checker.
// Used by the bound checker module only.
`ifndef MESH_FLOOD_DEDUPE_FILTER_TOP_ASSERT_SVH
`define MESH_FLOOD_DEDUPE_FILTER_TOP_ASSERT_SVH
// Implication checked on every clock while out of reset.
`define MFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define MFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/mfd_pkg.sv
// Shared types and constants for the mesh flood duplicate filter.
// No dependencies.
`timescale 1ns / 1ps
package mfd_pkg;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  PKT_LEN  = 8'd20;
    localparam logic [7:0]  CRC_SPAN = 8'd18;
    localparam logic [7:0]  HOPS_POS = 8'd17;
    localparam logic [7:0]  HOP_LIMIT_RST = 8'd4;
    localparam logic [15:0] GAP_RST = 16'd2000;

    typedef enum logic [1:0] {
        ST_NEW  = 2'd0,
        ST_LEN  = 2'd1,
        ST_CRC  = 2'd2,
        ST_DUP  = 2'd3
    } t_status;

    typedef enum logic {
        REG_HOP_LIMIT = 1'b0,
        REG_BRIDGE_GAP = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] now_ms;
        logic        wan_link_up;
        logic        wan_busy;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic        forward;
        logic        bridge;
        logic [15:0] source_id;
        logic [15:0] sequence_res;
        logic [7:0]  hops_out;
        logic [15:0] crc_out;
        logic [5:0]  cache_slot;
    } t_out_word;

    function automatic logic [15:0] crc_bit(input logic [15:0] c);
        crc_bit = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    endfunction
endpackage

// File: rtl/mesh_flood_dedupe_filter_top.sv
// Mesh flood duplicate filter: byte intake, CRC check, seen-cache walk.
// Depends on mfd_pkg.
//
// Usage: present one packet byte per command on i_in with i_start while
// o_busy is low. A byte inside the CRC span goes through a shared one-bit CRC
// shifter, and o_busy stays high until the shifter is done. Bytes past the
// CRC span skip the shifter. On the last byte of a 20-byte packet with a good
// CRC the cache memory is walked one slot a cycle; then, for a new packet
// that is forwarded, the new hop count is run through the CRC shifter.
// One result word per last byte appears on o_out for one cycle with o_valid,
// whether the packet is dropped on length or CRC, found in the cache or new.
// The receiver cannot stall.
// Configuration writes on i_cfg_* are taken at any time (o_cfg_ready is tied
// high) and must be made while the block is idle.
// Reset (synchronous, active low) clears the packet state, cache valid bits,
// bridge timer and registers; no clearing pass is needed. Cache contents are
// only read where the slot's valid bit is set.
`timescale 1ns / 1ps
module mesh_flood_dedupe_filter_top #(
    parameter int CACHE_ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mfd_pkg::t_in_word  i_in,
    output logic               o_busy,
    output logic               o_valid,
    output mfd_pkg::t_out_word o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [0:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam int AW = $clog2(CACHE_ENTRIES);
    localparam int CW = $clog2(CACHE_ENTRIES + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CRC, S_FIND, S_FINISH, S_HOPCRC, S_EMIT
    } t_state;

    t_state      r_state;
    logic [7:0]  r_hop_limit;
    logic [15:0] r_gap_ms;
    logic [7:0]  r_count;
    logic [15:0] r_crc, r_crc_pre, r_src, r_seq, r_rx_crc;
    logic [7:0]  r_hops, r_byte;
    logic [2:0]  r_bit;
    logic        r_last;
    logic [31:0] r_now, r_last_bridge;
    logic        r_joined, r_wbusy;
    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_rd_idx;
    logic        r_rd_ok;
    logic        r_found, r_have_old;
    logic [AW-1:0] r_slot, r_old_slot;
    logic [31:0] r_oldest;
    logic        r_free;
    logic [AW-1:0] r_free_slot;
    mfd_pkg::t_out_word r_out;
    logic        r_ovalid;

    logic [15:0] m_src [CACHE_ENTRIES];
    logic [15:0] m_seq [CACHE_ENTRIES];
    logic [31:0] m_time [CACHE_ENTRIES];
    logic [15:0] r_m_src, r_m_seq;
    logic [31:0] r_m_time;
    logic        r_m_we;
    logic [AW-1:0] r_m_wa;

    logic [7:0]  n_count;
    assign n_count = (r_count == 8'hFF) ? r_count : r_count + 8'd1;

    assign o_busy = (r_state != S_IDLE);
    assign o_valid = r_ovalid;
    assign o_out = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        r_m_src  <= m_src[r_idx[AW-1:0]];
        r_m_seq  <= m_seq[r_idx[AW-1:0]];
        r_m_time <= m_time[r_idx[AW-1:0]];
        if (r_m_we) begin
            m_src[r_m_wa]  <= r_src;
            m_seq[r_m_wa]  <= r_seq;
            m_time[r_m_wa] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hop_limit <= mfd_pkg::HOP_LIMIT_RST;
            r_gap_ms <= mfd_pkg::GAP_RST;
            r_count <= '0;
            r_crc <= mfd_pkg::CRC_INIT;
            r_crc_pre <= mfd_pkg::CRC_INIT;
            r_src <= '0;
            r_seq <= '0;
            r_hops <= '0;
            r_rx_crc <= '0;
            r_valid <= '0;
            r_last_bridge <= '0;
            r_ovalid <= 1'b0;
            r_m_we <= 1'b0;
            r_rd_ok <= 1'b0;
        end else begin
            r_ovalid <= 1'b0;
            r_m_we <= 1'b0;
            if (i_cfg_valid) begin
                unique case (mfd_pkg::t_reg_idx'(i_cfg_index))
                    mfd_pkg::REG_HOP_LIMIT:  r_hop_limit <= i_cfg_data[7:0];
                    mfd_pkg::REG_BRIDGE_GAP: r_gap_ms <= i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_byte <= i_in.data_byte;
                        r_last <= i_in.last_byte;
                        r_now <= i_in.now_ms;
                        r_joined <= i_in.wan_link_up;
                        r_wbusy <= i_in.wan_busy;
                        r_count <= n_count;
                        r_bit <= '0;
                        if (r_count == mfd_pkg::HOPS_POS) begin
                            r_crc_pre <= r_crc;
                            r_hops <= i_in.data_byte;
                        end
                        if (r_count == 8'd0) r_src[7:0] <= i_in.data_byte;
                        if (r_count == 8'd1) r_src[15:8] <= i_in.data_byte;
                        if (r_count == 8'd2) r_seq[7:0] <= i_in.data_byte;
                        if (r_count == 8'd3) r_seq[15:8] <= i_in.data_byte;
                        if (r_count == 8'd18) r_rx_crc[7:0] <= i_in.data_byte;
                        if (r_count == 8'd19) r_rx_crc[15:8] <= i_in.data_byte;
                        if (r_count < mfd_pkg::CRC_SPAN) begin
                            r_crc <= r_crc ^ {i_in.data_byte, 8'h00};
                            r_state <= S_CRC;
                        end else begin
                            r_state <= S_FINISH;
                        end
                    end
                end
                S_CRC: begin
                    r_crc <= mfd_pkg::crc_bit(r_crc);
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    priority if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (r_count != mfd_pkg::PKT_LEN) begin
                        r_out <= '{status: mfd_pkg::ST_LEN, default: '0};
                        r_state <= S_EMIT;
                    end else if (r_crc != r_rx_crc) begin
                        r_out <= '{status: mfd_pkg::ST_CRC, forward: 1'b0,
                                   bridge: 1'b0, source_id: r_src,
                                   sequence_res: r_seq, hops_out: r_hops,
                                   crc_out: r_crc, cache_slot: 6'd0};
                        r_state <= S_EMIT;
                    end else begin
                        r_idx <= '0;
                        r_rd_ok <= 1'b0;
                        r_found <= 1'b0;
                        r_free <= 1'b0;
                        r_have_old <= 1'b0;
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_rd_idx <= r_idx[AW-1:0];
                    r_rd_ok <= (r_idx < CW'(CACHE_ENTRIES));
                    if (r_idx < CW'(CACHE_ENTRIES)) r_idx <= r_idx + CW'(1);
                    if (r_rd_ok) begin
                        if (r_valid[r_rd_idx]) begin
                            if (!r_found && r_m_src == r_src && r_m_seq == r_seq) begin
                                r_found <= 1'b1;
                                r_slot <= r_rd_idx;
                            end
                            if (!r_free && (!r_have_old || r_m_time < r_oldest)) begin
                                r_oldest <= r_m_time;
                                r_old_slot <= r_rd_idx;
                                r_have_old <= 1'b1;
                            end
                        end else if (!r_free) begin
                            r_free <= 1'b1;
                            r_free_slot <= r_rd_idx;
                        end
                    end
                    if (!r_rd_ok && r_idx == CW'(CACHE_ENTRIES)) begin
                        r_out.source_id <= r_src;
                        r_out.sequence_res <= r_seq;
                        r_out.forward <= 1'b0;
                        r_out.bridge <= 1'b0;
                        r_out.hops_out <= r_hops;
                        r_out.crc_out <= r_crc;
                        if (r_found) begin
                            r_out.status <= mfd_pkg::ST_DUP;
                            r_out.cache_slot <= 6'(r_slot);
                            r_state <= S_EMIT;
                        end else begin
                            r_out.status <= mfd_pkg::ST_NEW;
                            r_out.cache_slot <= 6'(r_free ? r_free_slot : r_old_slot);
                            r_m_we <= 1'b1;
                            r_m_wa <= r_free ? r_free_slot : r_old_slot;
                            r_valid[r_free ? r_free_slot : r_old_slot] <= 1'b1;
                            if (r_joined && !r_wbusy &&
                                (r_now - r_last_bridge) >= {16'd0, r_gap_ms}) begin
                                r_out.bridge <= 1'b1;
                                r_last_bridge <= r_now;
                            end
                            if (r_hops < r_hop_limit) begin
                                r_out.forward <= 1'b1;
                                r_out.hops_out <= r_hops + 8'd1;
                                r_crc <= r_crc_pre ^ {r_hops + 8'd1, 8'h00};
                                r_bit <= '0;
                                r_state <= S_HOPCRC;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_HOPCRC: begin
                    r_crc <= mfd_pkg::crc_bit(r_crc);
                    r_bit <= r_bit + 3'd1;
                    if (r_bit == 3'd7) begin
                        r_out.crc_out <= mfd_pkg::crc_bit(r_crc);
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_ovalid <= 1'b1;
                    r_count <= '0;
                    r_crc <= mfd_pkg::CRC_INIT;
                    r_crc_pre <= mfd_pkg::CRC_INIT;
                    r_src <= '0;
                    r_seq <= '0;
                    r_hops <= '0;
                    r_rx_crc <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// File: rtl/mfd_checker.sv
// Port-level checker for the flood filter, bound to the top level.
// Depends on mfd_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "mesh_flood_dedupe_filter_top_assert.svh"
module mfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               o_valid,
    input mfd_pkg::t_out_word o_out
);
    `MFD_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy,
        "start not taken")
    `MFD_ASSERT_IMP(a_len_zero, i_clk, i_rst_n,
        o_valid && o_out.status == mfd_pkg::ST_LEN,
        !o_out.forward && !o_out.bridge && o_out.source_id == 16'd0,
        "length drop not cleared")
    `MFD_ASSERT_IMP(a_drop_noreq, i_clk, i_rst_n,
        o_valid && (o_out.status == mfd_pkg::ST_CRC || o_out.status == mfd_pkg::ST_DUP),
        !o_out.forward && !o_out.bridge, "request on drop")
    `MFD_ASSERT_NXT(a_single, i_clk, i_rst_n, o_valid, !o_valid, "result repeated")
endmodule

bind mesh_flood_dedupe_filter_top mfd_checker u_mfd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start),
    .o_busy(o_busy), .o_valid(o_valid), .o_out(o_out)
);
